// ===== rtl/twmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twmf_pkg
// Shared constants and types of the threshold window mean filter.
// ----------------------------------------------------------------------------
package twmf_pkg;

  // Defaults of the top-level parameters
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_RADIUS_DEF = 7;
  localparam int PIXEL_BITS_DEF = 16;

  // Fixed limits and widths
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 16;   // pixel field width
  localparam int ROW_W      = 12;   // row index, 0..MAX_HEIGHT-1
  localparam int HCNT_W     = 13;   // row count, 0..MAX_HEIGHT
  localparam int RAD_W      = 3;
  localparam int THR_W      = 16;
  localparam int SIZE_W     = 13;   // image_width / image_height registers
  localparam int CNT_W      = 8;    // neighbour count, at most 227
  localparam int SUM_W      = 24;   // weighted sum, at most 227 * 65535
  localparam int NUM_W      = 25;   // 2 * sum + count
  localparam int QUO_W      = 16;   // quotient bits, one per divider cell
  localparam int REM_W      = 9;    // remainder, below the 9-bit divisor
  localparam int DEN_W      = 9;    // 2 * count

  // Register map (index = byte address / 4)
  localparam logic [2:0] REG_THRESHOLD    = 3'd0;
  localparam logic [2:0] REG_RADIUS       = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ENABLE       = 3'd4;

  // One stage of the divider chain
  typedef struct packed {
    logic             valid;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] low;   // dividend bits still to consume, quotient bits shift in
    logic [DEN_W-1:0] den;
  } div_stage_t;

endpackage

// ===== rtl/threshold_window_mean_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_window_mean_filter
// Thresholded neighbourhood mean over a raster plane, with line stores in RAM
// and a chain of division cells for the rounded mean.
// One input item at a time, taken only while idle. An item that yields no result
// is just stored. An item with a filtered result reads N window pixels, N the
// clipped window size (up to 225), one RAM read per window pixel on the single
// RAM port, then passes the divider chain; pass-through results read the centre.
// Reset (rst, synchronous): clear counters, handshakes and state; load the
// register defaults. Line-store RAM contents are left as they are.
// ----------------------------------------------------------------------------
module threshold_window_mean_filter import twmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // input stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // [15:0] pixel_in
  input  logic             s_tuser,   // [0] flush
  // output stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // [15:0] pixel_out
  output logic             m_tlast,   // frame_end
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
  localparam int RING_W    = $clog2(RING_ROWS);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int LAG_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_WRITE  = 4'd1;
  localparam logic [3:0] ST_EVAL   = 4'd2;
  localparam logic [3:0] ST_CENTRE = 4'd3;
  localparam logic [3:0] ST_SCAN   = 4'd4;
  localparam logic [3:0] ST_DRAIN  = 4'd5;
  localparam logic [3:0] ST_FEED   = 4'd6;
  localparam logic [3:0] ST_CAPT   = 4'd7;
  localparam logic [3:0] ST_WAITQ  = 4'd8;
  localparam logic [3:0] ST_RESULT = 4'd9;

  // Configuration registers
  logic [THR_W-1:0]  threshold;
  logic [RAD_W-1:0]  radius;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic              enable;

  // Settings latched at the first pixel of a frame
  logic [WCNT_W-1:0] act_w;
  logic [HCNT_W-1:0] act_h;
  logic [RAD_W-1:0]  act_r;
  logic [THR_W-1:0]  act_thr;
  logic              act_en;
  logic [LAG_W-1:0]  delay;

  // Position counters
  logic [COL_W-1:0]  in_col;
  logic [HCNT_W-1:0] in_row;
  logic [RING_W-1:0] in_ring;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [RING_W-1:0] out_ring;
  logic [LAG_W-1:0]  lag;      // pixels stored minus results given

  logic [3:0]        state;
  logic [PIX_W-1:0]  pix_q;
  logic              flush_q;

  // Window scan
  logic [ROW_W-1:0]  y_hi;
  logic [COL_W-1:0]  x_lo, x_hi;
  logic [ROW_W-1:0]  sy;
  logic [COL_W-1:0]  sx;
  logic [RING_W-1:0] sring;
  logic              pend_c, pend_n;
  logic [PIX_W-1:0]  centre;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;
  logic [PIX_W-1:0]  res;

  // RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_rdata;

  div_stage_t div_in, div_out;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [RING_W-1:0] ring,
                                                input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col));
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THR_W'(10);
      radius       <= RAD_W'(1);
      image_width  <= SIZE_W'(1920);
      image_height <= SIZE_W'(1080);
      enable       <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESHOLD:    threshold    <= pwdata[THR_W-1:0];
        REG_RADIUS:       radius       <= pwdata[RAD_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[SIZE_W-1:0];
        REG_ENABLE:       enable       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD:    prdata = 32'(threshold);
      REG_RADIUS:       prdata = 32'(radius);
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      REG_ENABLE:       prdata = 32'(enable);
      default:          prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Clipped register values, taken at the first pixel of a frame
  // --------------------------------------------------------------------------
  logic [WCNT_W-1:0] w_clip;
  logic [HCNT_W-1:0] h_clip;
  logic [RAD_W-1:0]  r_clip;

  always_comb begin
    if (image_width == '0) w_clip = WCNT_W'(1);
    else if (32'(image_width) > MAX_WIDTH) w_clip = WCNT_W'(MAX_WIDTH);
    else w_clip = WCNT_W'(image_width);
    if (image_height == '0) h_clip = HCNT_W'(1);
    else if (32'(image_height) > MAX_HEIGHT) h_clip = HCNT_W'(MAX_HEIGHT);
    else h_clip = HCNT_W'(image_height);
    if (32'(radius) > MAX_RADIUS) r_clip = RAD_W'(MAX_RADIUS);
    else r_clip = radius;
  end

  // --------------------------------------------------------------------------
  // Write-step decode
  // --------------------------------------------------------------------------
  logic              in_done;
  logic              stored;
  logic              latch;
  logic [WCNT_W-1:0] w_use;

  assign in_done = (in_row >= act_h);
  assign stored  = !in_done && !flush_q;
  assign latch   = stored && (in_row == '0) && (in_col == '0);
  assign w_use   = latch ? w_clip : act_w;

  // --------------------------------------------------------------------------
  // Window bounds for the result at (out_row, out_col)
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]  y_lo_c, y_hi_c;
  logic [COL_W-1:0]  x_lo_c, x_hi_c;
  logic [ROW_W:0]    y_sum;
  logic [COL_W:0]    x_sum;
  logic [RAD_W-1:0]  k_up;
  logic [RING_W:0]   ring_lo;
  logic              emit;
  logic              last_out;

  always_comb begin
    y_lo_c = (out_row >= ROW_W'(act_r)) ? out_row - ROW_W'(act_r) : '0;
    y_sum  = {1'b0, out_row} + (ROW_W+1)'(act_r);
    y_hi_c = (HCNT_W'(y_sum) < act_h) ? y_sum[ROW_W-1:0] : ROW_W'(act_h - 1'b1);
    x_lo_c = (out_col >= COL_W'(act_r)) ? out_col - COL_W'(act_r) : '0;
    x_sum  = {1'b0, out_col} + (COL_W+1)'(act_r);
    x_hi_c = (WCNT_W'(x_sum) < act_w) ? x_sum[COL_W-1:0] : COL_W'(act_w - 1'b1);
    k_up   = RAD_W'(out_row - y_lo_c);
    if ((RING_W+1)'(out_ring) >= (RING_W+1)'(k_up))
      ring_lo = (RING_W+1)'(out_ring) - (RING_W+1)'(k_up);
    else
      ring_lo = (RING_W+1)'(out_ring) + (RING_W+1)'(RING_ROWS) - (RING_W+1)'(k_up);
  end

  assign emit     = in_done || (!flush_q && (lag > delay));
  assign last_out = (HCNT_W'(out_row) == act_h - 1'b1) &&
                    (WCNT_W'(out_col) == act_w - 1'b1);

  // Neighbour test on the word read last cycle
  logic [PIX_W-1:0] diff;
  assign diff = (ram_rdata > centre) ? ram_rdata - centre : centre - ram_rdata;

  // --------------------------------------------------------------------------
  // RAM port: write in the write step, read in the centre step and the window scan
  // --------------------------------------------------------------------------
  always_comb begin
    ram_we   = (state == ST_WRITE) && stored;
    ram_addr = addr_of(in_ring, in_col);
    case (state)
      ST_CENTRE: ram_addr = addr_of(out_ring, out_col);
      ST_SCAN:   ram_addr = addr_of(sring, sx);
      default:   ram_addr = addr_of(in_ring, in_col);
    endcase
  end

  twmf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pix_q),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Divider chain: filtered mean, or the bare pixel divided by one
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0] num;

  always_comb begin
    div_in = '0;
    if (state == ST_FEED) begin
      num          = NUM_W'({sum, 1'b0}) + NUM_W'(count);
      div_in.valid = 1'b1;
      div_in.den   = {count, 1'b0};
    end else begin
      num          = NUM_W'(ram_rdata);
      div_in.valid = (state == ST_CAPT);
      div_in.den   = DEN_W'(1);
    end
    div_in.rem = num[NUM_W-1:QUO_W];
    div_in.low = num[QUO_W-1:0];
  end

  twmf_div_chain u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (div_in),
    .dout (div_out)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    // accumulate neighbours as read data returns
    if (pend_c) begin
      centre <= ram_rdata;
      sum    <= SUM_W'({ram_rdata, 1'b0});
      count  <= CNT_W'(2);
    end else if (pend_n && (diff < act_thr)) begin
      sum    <= sum + SUM_W'(ram_rdata);
      count  <= count + 1'b1;
    end
    if (div_out.valid) begin
      res <= div_out.low;
    end

    if (rst) begin
      state    <= ST_IDLE;
      pend_c   <= 1'b0;
      pend_n   <= 1'b0;
      m_tvalid <= 1'b0;
      in_col   <= '0;
      in_row   <= '0;
      in_ring  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_ring <= '0;
      lag      <= '0;
      act_w    <= WCNT_W'(1920);
      act_h    <= HCNT_W'(1080);
      act_r    <= RAD_W'(1);
      act_thr  <= THR_W'(10);
      act_en   <= 1'b1;
      delay    <= LAG_W'(1921);
    end else begin
      pend_c <= (state == ST_CENTRE) && act_en;
      pend_n <= (state == ST_SCAN);
      // drop the output item once taken, unless a new one replaces it
      if (m_tvalid && m_tready && (state != ST_RESULT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            pix_q   <= s_tdata & PIX_MASK;
            flush_q <= s_tuser;
            state   <= ST_WRITE;
          end
        end

        ST_WRITE: begin
          // store the pixel and advance the input position
          if (latch) begin
            act_w   <= w_clip;
            act_h   <= h_clip;
            act_r   <= r_clip;
            act_thr <= threshold;
            act_en  <= enable;
            delay   <= enable ? LAG_W'(r_clip) * LAG_W'(w_clip) + LAG_W'(r_clip) : '0;
          end
          if (stored) begin
            lag <= lag + 1'b1;
            if (WCNT_W'(in_col) + 1'b1 >= w_use) begin
              in_col  <= '0;
              in_row  <= in_row + 1'b1;
              in_ring <= (32'(in_ring) == RING_ROWS - 1) ? '0 : in_ring + 1'b1;
            end else begin
              in_col <= in_col + 1'b1;
            end
          end
          state <= ST_EVAL;
        end

        ST_EVAL: begin
          y_hi  <= y_hi_c;
          x_lo  <= x_lo_c;
          x_hi  <= x_hi_c;
          sy    <= y_lo_c;
          sx    <= x_lo_c;
          sring <= ring_lo[RING_W-1:0];
          state <= emit ? ST_CENTRE : ST_IDLE;
        end

        ST_CENTRE: begin
          state <= act_en ? ST_SCAN : ST_CAPT;
        end

        ST_SCAN: begin
          // one window read per cycle, row by row
          if (sx == x_hi) begin
            sx <= x_lo;
            if (sy == y_hi) begin
              state <= ST_DRAIN;
            end else begin
              sy    <= sy + 1'b1;
              sring <= (32'(sring) == RING_ROWS - 1) ? '0 : sring + 1'b1;
            end
          end else begin
            sx <= sx + 1'b1;
          end
        end

        ST_DRAIN: state <= ST_FEED;
        ST_FEED:  state <= ST_WAITQ;
        ST_CAPT:  state <= ST_WAITQ;

        ST_WAITQ: begin
          if (div_out.valid) begin
            state <= ST_RESULT;
          end
        end

        ST_RESULT: begin
          // hand the result over once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            m_tlast  <= last_out;
            if (last_out) begin
              in_col   <= '0;
              in_row   <= '0;
              in_ring  <= '0;
              out_col  <= '0;
              out_row  <= '0;
              out_ring <= '0;
              lag      <= '0;
            end else begin
              lag <= lag - 1'b1;
              if (WCNT_W'(out_col) + 1'b1 >= act_w) begin
                out_col  <= '0;
                out_row  <= out_row + 1'b1;
                out_ring <= (32'(out_ring) == RING_ROWS - 1) ? '0 : out_ring + 1'b1;
              end else begin
                out_col <= out_col + 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/twmf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twmf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module twmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/twmf_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twmf_div_cell
// One restoring-division step: produce one quotient bit, pass on.
// ----------------------------------------------------------------------------
module twmf_div_cell import twmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  div_stage_t din,
  output div_stage_t dout
);

  logic [REM_W:0] trial;
  logic           take;

  assign trial = {din.rem, din.low[QUO_W-1]};
  assign take  = (trial >= {1'b0, din.den});

  always_ff @(posedge clk) begin
    dout.rem <= take ? REM_W'(trial - {1'b0, din.den}) : trial[REM_W-1:0];
    dout.low <= {din.low[QUO_W-2:0], take};
    dout.den <= din.den;
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

endmodule

// ===== rtl/twmf_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twmf_div_chain
// Row of division cells; the quotient leaves in the low field of the last cell.
// ----------------------------------------------------------------------------
module twmf_div_chain import twmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  div_stage_t din,
  output div_stage_t dout
);

  div_stage_t stage [QUO_W+1];

  assign stage[0] = din;

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    twmf_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  assign dout = stage[QUO_W];

endmodule
